// ===== sv/host_key_to_matrix_mapper_defines.svh =====
// assertion macros for the host key to matrix mapper
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef HOST_KEY_TO_MATRIX_MAPPER_DEFINES_SVH
`define HOST_KEY_TO_MATRIX_MAPPER_DEFINES_SVH

// checked only while out of reset
`define HKMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define HKMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/hkmm_pkg.sv =====
// shared constants, types and lookup functions for the key to matrix mapper
// no dependencies
`default_nettype none

package hkmm_pkg;

  localparam int unsigned MATRIX_W = 40;
  localparam int unsigned ROW_W    = 5;

  // request kinds
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_AXIS    = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // key codes
  localparam logic [5:0] KEY_O      = 6'd14;
  localparam logic [5:0] KEY_P      = 6'd15;
  localparam logic [5:0] KEY_DIGIT0 = 6'd26;
  localparam logic [5:0] KEY_DIGIT1 = 6'd27;
  localparam logic [5:0] KEY_DIGIT9 = 6'd35;
  localparam logic [5:0] KEY_TAB    = 6'd43;
  localparam logic [5:0] KEY_ESC    = 6'd44;
  localparam logic [5:0] KEY_UP     = 6'd45;
  localparam logic [5:0] KEY_DOWN   = 6'd46;
  localparam logic [5:0] KEY_LEFT   = 6'd47;
  localparam logic [5:0] KEY_RIGHT  = 6'd48;
  localparam logic [5:0] KEY_FIRE   = 6'd49;
  localparam logic [5:0] KEY_F1     = 6'd50;
  localparam logic [5:0] KEY_F10    = 6'd59;
  localparam logic [5:0] KEY_F11    = 6'd60;
  localparam logic [5:0] KEY_F12    = 6'd61;

  // joystick modes
  localparam logic [1:0] JOY_CURSOR = 2'd0;
  localparam logic [1:0] JOY_DIRECT = 2'd1;

  // command codes
  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_WARN = 4'd1;
  localparam logic [3:0] CMD_QUIT = 4'd2;

  // configuration register indexes
  localparam logic CFG_JOY_MODE = 1'b0;
  localparam logic CFG_ROTATED  = 1'b1;

  localparam logic signed [15:0] CENTER_LIMIT = 16'sd16384;

  typedef struct packed {
    logic [MATRIX_W-1:0] mask;
    logic [ROW_W-1:0]    jk;
  } key_eff_t;

  function automatic logic [MATRIX_W-1:0] km(input int unsigned r, input logic [4:0] b);
    km = {{(MATRIX_W-ROW_W){1'b0}}, b} << (ROW_W * r);
  endfunction

  function automatic logic [MATRIX_W-1:0] key_mask(input logic [5:0] code);
    logic [MATRIX_W-1:0] m;
    m = '0;
    case (code)
      6'd0:  m = km(1, 5'd1);
      6'd1:  m = km(7, 5'd16);
      6'd2:  m = km(0, 5'd8);
      6'd3:  m = km(1, 5'd4);
      6'd4:  m = km(2, 5'd4);
      6'd5:  m = km(1, 5'd8);
      6'd6:  m = km(1, 5'd16);
      6'd7:  m = km(6, 5'd16);
      6'd8:  m = km(5, 5'd4);
      6'd9:  m = km(6, 5'd8);
      6'd10: m = km(6, 5'd4);
      6'd11: m = km(6, 5'd2);
      6'd12: m = km(7, 5'd4);
      6'd13: m = km(7, 5'd8);
      6'd14: m = km(5, 5'd2);
      6'd15: m = km(5, 5'd1);
      6'd16: m = km(2, 5'd1);
      6'd17: m = km(2, 5'd8);
      6'd18: m = km(1, 5'd2);
      6'd19: m = km(2, 5'd16);
      6'd20: m = km(5, 5'd8);
      6'd21: m = km(0, 5'd16);
      6'd22: m = km(2, 5'd2);
      6'd23: m = km(0, 5'd4);
      6'd24: m = km(5, 5'd16);
      6'd25: m = km(0, 5'd2);
      6'd26: m = km(4, 5'd1);
      6'd27: m = km(3, 5'd1);
      6'd28: m = km(3, 5'd2);
      6'd29: m = km(3, 5'd4);
      6'd30: m = km(3, 5'd8);
      6'd31: m = km(3, 5'd16);
      6'd32: m = km(4, 5'd16);
      6'd33: m = km(4, 5'd8);
      6'd34: m = km(4, 5'd4);
      6'd35: m = km(4, 5'd2);
      6'd36: m = km(7, 5'd1);
      6'd37: m = km(6, 5'd1);
      6'd38: m = km(0, 5'd1);
      6'd39: m = km(7, 5'd2);
      6'd40: m = km(4, 5'd1) | km(0, 5'd1);
      6'd41: m = km(7, 5'd6);
      6'd42: m = km(7, 5'd10);
      default: m = '0;
    endcase
    return m;
  endfunction

  // digit for modes 0, 2, 3; stick bit for the direct mode
  function automatic logic [4:0] stick_val(input logic [2:0] dir, input logic [1:0] mode);
    logic [4:0] v;
    v = '0;
    case ({dir, mode})
      5'b000_00: v = 5'd7;
      5'b000_01: v = 5'd8;
      5'b000_10: v = 5'd4;
      5'b000_11: v = 5'd9;
      5'b001_00: v = 5'd6;
      5'b001_01: v = 5'd4;
      5'b001_10: v = 5'd3;
      5'b001_11: v = 5'd8;
      5'b010_00: v = 5'd5;
      5'b010_01: v = 5'd2;
      5'b010_10: v = 5'd2;
      5'b010_11: v = 5'd7;
      5'b011_00: v = 5'd8;
      5'b011_01: v = 5'd1;
      5'b011_10: v = 5'd1;
      5'b011_11: v = 5'd6;
      5'b100_00: v = 5'd0;
      5'b100_01: v = 5'd16;
      5'b100_10: v = 5'd5;
      5'b100_11: v = 5'd0;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] fkey_cmd(input logic [3:0] idx);
    logic [3:0] c;
    c = CMD_NONE;
    case (idx)
      4'd0:  c = 4'd3;
      4'd1:  c = 4'd4;
      4'd2:  c = 4'd5;
      4'd3:  c = 4'd6;
      4'd4:  c = 4'd9;
      4'd5:  c = 4'd10;
      4'd6:  c = 4'd7;
      4'd7:  c = 4'd8;
      4'd8:  c = 4'd11;
      4'd9:  c = 4'd12;
      4'd10: c = 4'd13;
      4'd11: c = 4'd14;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

  // digits, o and p become function keys
  function automatic logic [5:0] fkey_remap(input logic [5:0] code);
    logic [5:0] c;
    c = code;
    if (code == KEY_DIGIT0) begin
      c = KEY_F10;
    end else if (code >= KEY_DIGIT1 && code <= KEY_DIGIT9) begin
      c = code + (KEY_F1 - KEY_DIGIT1);
    end else if (code == KEY_O) begin
      c = KEY_F11;
    end else if (code == KEY_P) begin
      c = KEY_F12;
    end
    return c;
  endfunction

  // rotation, joystick mapping and matrix lookup of one key
  function automatic key_eff_t key_map(input logic [5:0] code, input logic [1:0] mode,
                                       input logic rot);
    logic [5:0] c;
    logic [4:0] v;
    key_eff_t   e;
    c = code;
    v = '0;
    e = '0;
    if (rot) begin
      if (code == KEY_UP) begin
        c = KEY_LEFT;
      end else if (code == KEY_LEFT) begin
        c = KEY_DOWN;
      end else if (code == KEY_DOWN) begin
        c = KEY_RIGHT;
      end else if (code == KEY_RIGHT) begin
        c = KEY_UP;
      end
    end
    if (c >= KEY_UP && c <= KEY_FIRE) begin
      v = stick_val(3'(c - KEY_UP), mode);
      if (mode == JOY_DIRECT) begin
        e.jk = v;
      end else begin
        e.mask = key_mask(KEY_DIGIT0 + {1'b0, v});
      end
    end else begin
      e.mask = key_mask(c);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== sv/host_key_to_matrix_mapper.sv =====
// host key to keyboard matrix mapper with joystick emulation, top level
// depends on hkmm_pkg and host_key_to_matrix_mapper_defines.svh
// result: registered into the output register, or into the skid entry while the output is stalled
// throughput: one request per cycle while the skid entry is empty; a two-entry output buffer keeps
// s_axis_tready high while one result waits downstream
// reset: all half-rows released, stick bits, flags, config and valid bits cleared; output data not reset
`default_nettype none

`include "host_key_to_matrix_mapper_defines.svh"

module host_key_to_matrix_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // key_code[5:0], axis[6], axis_value[22:7], pad
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata   // matrix[39:0], joystick_bits[44:40],
                                          // function_mode[45], command[49:46], pad
);

  logic [1:0]  joy_mode_q;
  logic        rotated_q;
  logic [39:0] rows_q, rows_d;
  logic [4:0]  stick_q, stick_d;
  logic        fkey_q, fkey_d;
  logic        armed_q, armed_d;
  logic [3:0]  cmd_d;

  logic [55:0] out_q, skid_q, res_d;
  logic        out_valid_q, skid_valid_q;
  logic        accept;

  logic [1:0]        action;
  logic [5:0]        key_code;
  logic              axis;
  logic signed [15:0] axis_value;

  logic [5:0]  code2, map1_code, first, second;
  logic        rel2, centred;
  hkmm_pkg::key_eff_t e1, e2;

  assign action     = s_axis_tuser;
  assign key_code   = s_axis_tdata[5:0];
  assign axis       = s_axis_tdata[6];
  assign axis_value = $signed(s_axis_tdata[22:7]);

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // axis event decomposition
  always_comb begin
    centred = (axis_value < hkmm_pkg::CENTER_LIMIT) && (axis_value > -hkmm_pkg::CENTER_LIMIT);
    rel2    = centred;
    if (centred) begin
      first  = axis ? hkmm_pkg::KEY_DOWN : hkmm_pkg::KEY_LEFT;
      second = axis ? hkmm_pkg::KEY_UP : hkmm_pkg::KEY_RIGHT;
    end else if (!axis) begin
      first  = axis_value[15] ? hkmm_pkg::KEY_RIGHT : hkmm_pkg::KEY_LEFT;
      second = axis_value[15] ? hkmm_pkg::KEY_LEFT : hkmm_pkg::KEY_RIGHT;
    end else begin
      first  = axis_value[15] ? hkmm_pkg::KEY_DOWN : hkmm_pkg::KEY_UP;
      second = axis_value[15] ? hkmm_pkg::KEY_UP : hkmm_pkg::KEY_DOWN;
    end
  end

  assign code2     = (action == hkmm_pkg::ACT_RELEASE && fkey_q) ?
                     hkmm_pkg::fkey_remap(key_code) : key_code;
  assign map1_code = (action == hkmm_pkg::ACT_AXIS) ? first : code2;
  assign e1        = hkmm_pkg::key_map(map1_code, joy_mode_q, rotated_q);
  assign e2        = hkmm_pkg::key_map(second, joy_mode_q, rotated_q);

  always_comb begin
    rows_d  = rows_q;
    stick_d = stick_q;
    fkey_d  = fkey_q;
    armed_d = armed_q;
    cmd_d   = hkmm_pkg::CMD_NONE;
    unique case (action)
      hkmm_pkg::ACT_PRESS: begin
        if (!fkey_q) begin
          rows_d  = rows_q & ~e1.mask;
          stick_d = stick_q | e1.jk;
        end
      end
      hkmm_pkg::ACT_RELEASE: begin
        if (key_code == hkmm_pkg::KEY_TAB) begin
          fkey_d = !fkey_q;
        end else begin
          fkey_d = 1'b0;
          if (code2 == hkmm_pkg::KEY_ESC) begin
            armed_d = 1'b1;
            cmd_d   = armed_q ? hkmm_pkg::CMD_QUIT : hkmm_pkg::CMD_WARN;
          end else begin
            if (code2 >= hkmm_pkg::KEY_F1 && code2 <= hkmm_pkg::KEY_F12) begin
              cmd_d = hkmm_pkg::fkey_cmd(4'(code2 - hkmm_pkg::KEY_F1));
            end
            rows_d  = rows_q | e1.mask;
            stick_d = stick_q & ~e1.jk;
          end
        end
      end
      hkmm_pkg::ACT_AXIS: begin
        fkey_d = 1'b0;
        if (rel2) begin
          rows_d  = rows_q | e1.mask | e2.mask;
          stick_d = stick_q & ~e1.jk & ~e2.jk;
        end else begin
          rows_d  = (rows_q | e1.mask) & ~e2.mask;
          stick_d = (stick_q & ~e1.jk) | e2.jk;
        end
      end
      hkmm_pkg::ACT_CLEAR: begin
        rows_d  = '1;
        stick_d = '0;
      end
      default: begin
        rows_d = rows_q;
      end
    endcase
  end

  assign res_d = {6'd0, cmd_d, fkey_d, stick_d, rows_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joy_mode_q <= hkmm_pkg::JOY_CURSOR;
      rotated_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hkmm_pkg::CFG_JOY_MODE: joy_mode_q <= cfg_data_i;
        hkmm_pkg::CFG_ROTATED:  rotated_q  <= cfg_data_i[0];
        default:                rotated_q  <= rotated_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= '1;
      stick_q <= '0;
      fkey_q  <= 1'b0;
      armed_q <= 1'b0;
    end else if (accept) begin
      rows_q  <= rows_d;
      stick_q <= stick_d;
      fkey_q  <= fkey_d;
      armed_q <= armed_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  `HKMM_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `HKMM_ASSERT(a_armed_sticks, armed_q |=> armed_q, "exit flag cleared without reset")
  `HKMM_ASSERT(a_clear_all, (accept && action == hkmm_pkg::ACT_CLEAR) |=> (rows_q == '1 && stick_q == '0), "release all left keys down")
  `HKMM_ASSERT(a_axis_ends_fkey, (accept && action == hkmm_pkg::ACT_AXIS) |=> !fkey_q, "axis event kept function mode")
  `HKMM_ASSERT(a_fkey_press_ignored, (accept && action == hkmm_pkg::ACT_PRESS && fkey_q) |=> ($stable(rows_q) && $stable(stick_q)), "press in function mode changed keys")

endmodule

`default_nettype wire
